### rtl/pfba_pkg.sv
// Shared types and constants of the page frame bitmap allocator.
package pfba_pkg;

   localparam int NUM_FRAMES_DEF = 4096;   // default map size in frames
   localparam int FRAME_SHIFT    = 12;     // log2 of the 4096-byte frame size
   localparam int COUNT_W        = 13;     // frame_count width
   localparam int ADDR_W         = 24;     // byte address width
   localparam int SCAN_BITS      = 8;      // frames held in one memory row
   localparam int POS_W          = $clog2(SCAN_BITS);
   localparam int REQ_DATA_W     = 40;     // COUNT_W + ADDR_W, padded to bytes
   localparam int RSP_DATA_W     = 32;     // ADDR_W + 1, padded to bytes

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   // Control from the sequencer into the run finder.
   typedef struct packed {
      logic clr;   // restart the run count
      logic vld;   // a row of the map is on the read data
   } scan_ctl_type;

endpackage

### rtl/page_frame_bitmap_allocator_unit.sv
// Top level of the page frame bitmap allocator: sequencer, row update and result register.
//
// channel  direction  tdata (low bit up)                    tuser
// req_     in         frame_count[12:0], byte_address[36:13] func (0 alloc, 1 free)
// rsp_     out        address[23:0], ok[24]                  -
//
// Memory: the map lives in a memory of DEPTH = ceil(NUM_FRAMES/8) rows of 8 frames,
// one read and one write a cycle. An allocate reads rows from row 0 one per cycle
// until a run fits, then updates the rows the run touches; a free updates its rows
// directly. Rejected requests go straight to the result state.
// Reset: a clearing pass over all DEPTH rows (512 at the default size) zeroes the map;
// req_tready stays low until it ends.
// Stalls: the next word is accepted while a result waits in the output register; a
// finished item holds in the result state until that register is free.
module page_frame_bitmap_allocator_unit #(
   parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pfba_pkg::REQ_DATA_W-1:0] req_tdata,  // frame_count, byte_address
   input  logic                            req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0] rsp_tdata   // address, ok
);

   localparam int DEPTH   = (NUM_FRAMES + pfba_pkg::SCAN_BITS - 1) / pfba_pkg::SCAN_BITS;
   localparam int ROW_W   = $clog2(DEPTH);
   localparam int RCNT_W  = $clog2(DEPTH + 1);
   localparam int FRAME_W = $clog2(NUM_FRAMES + 1);
   localparam int SUM_W   = ((FRAME_W > pfba_pkg::COUNT_W) ? FRAME_W : pfba_pkg::COUNT_W) + 1;
   localparam int SF_W    = pfba_pkg::ADDR_W - pfba_pkg::FRAME_SHIFT;
   localparam int BITS    = pfba_pkg::SCAN_BITS;

   // ---------------------------------------------------------------- state
   pfba_pkg::state_type           state_ff, state_in;
   logic [ROW_W-1:0]              clr_row_ff, clr_row_in;
   logic [RCNT_W-1:0]             iss_ff, iss_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [ROW_W-1:0]              rd_row_ff, rd_row_in;
   logic [pfba_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [FRAME_W-1:0]            lo_ff, lo_in, hi_ff, hi_in;
   logic [ROW_W-1:0]              mlast_ff, mlast_in;
   logic                          val_ff, val_in;
   logic [pfba_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic                          ok_ff, ok_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [pfba_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // ---------------------------------------------------------------- memory side
   logic                  mem_we;
   logic [ROW_W-1:0]      mem_waddr, mem_raddr;
   logic [BITS-1:0]       mem_wdata, mem_rdata;
   logic                  rd_issue;
   logic [BITS-1:0]       row_mask;

   // ---------------------------------------------------------------- request decode
   logic                         req_acc;
   logic [pfba_pkg::COUNT_W-1:0] req_count;
   logic [pfba_pkg::ADDR_W-1:0]  req_baddr;
   logic [SF_W-1:0]              req_sf;
   logic [SUM_W-1:0]             free_sum;
   logic                         free_empty, alloc_bad;
   logic [FRAME_W-1:0]           free_hi, free_lo;

   // ---------------------------------------------------------------- run finder
   pfba_pkg::scan_ctl_type scan_ctl;
   logic                   scan_hit;
   logic [FRAME_W-1:0]     scan_end;
   logic [FRAME_W-1:0]     hit_lo;

   assign req_tready = (state_ff == pfba_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_count  = req_tdata[pfba_pkg::COUNT_W-1:0];
   assign req_baddr  = req_tdata[pfba_pkg::COUNT_W +: pfba_pkg::ADDR_W];
   assign req_sf     = req_baddr[pfba_pkg::ADDR_W-1:pfba_pkg::FRAME_SHIFT];

   // Free range: clip the end at the map size; a start beyond the map touches nothing.
   assign free_sum   = SUM_W'(req_sf) + SUM_W'(req_count);
   assign free_empty = (req_count == '0) || (SUM_W'(req_sf) >= SUM_W'(NUM_FRAMES));
   assign free_hi    = (free_sum > SUM_W'(NUM_FRAMES)) ? FRAME_W'(NUM_FRAMES)
                                                        : FRAME_W'(free_sum);
   assign free_lo    = FRAME_W'(req_sf);
   assign alloc_bad  = (req_count == '0) || (SUM_W'(req_count) > SUM_W'(NUM_FRAMES));

   assign hit_lo     = scan_end - FRAME_W'(count_ff);

   assign scan_ctl.clr = req_acc;
   assign scan_ctl.vld = (state_ff == pfba_pkg::ST_SCAN) && rd_vld_ff;

   pfba_run_scan #(
      .ROW_W   (ROW_W),
      .FRAME_W (FRAME_W)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .row     (rd_row_ff),
      .data    (mem_rdata),
      .count   (count_ff),
      .hit     (scan_hit),
      .hit_end (scan_end)
   );

   pfba_bitmap_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Frames of the row on the read data that fall inside [lo, hi).
   always_comb begin
      for (int j = 0; j < BITS; j++) begin
         row_mask[j] = (FRAME_W'({rd_row_ff, pfba_pkg::POS_W'(j)}) >= lo_ff) &&
                       (FRAME_W'({rd_row_ff, pfba_pkg::POS_W'(j)}) <  hi_ff);
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfba_pkg::ST_CLEAR: begin
            if (clr_row_ff == ROW_W'(DEPTH - 1)) begin
               state_in = pfba_pkg::ST_IDLE;
            end
         end
         pfba_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == pfba_pkg::FUNC_FREE) begin
                  state_in = free_empty ? pfba_pkg::ST_RESP : pfba_pkg::ST_MARK;
               end else begin
                  state_in = alloc_bad ? pfba_pkg::ST_RESP : pfba_pkg::ST_SCAN;
               end
            end
         end
         pfba_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = pfba_pkg::ST_MARK;
            end else if (rd_vld_ff && rd_row_ff == ROW_W'(DEPTH - 1)) begin
               state_in = pfba_pkg::ST_RESP;
            end
         end
         pfba_pkg::ST_MARK: begin
            if (rd_vld_ff && rd_row_ff == mlast_ff) begin
               state_in = pfba_pkg::ST_RESP;
            end
         end
         pfba_pkg::ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = pfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfba_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs and datapath
   always_comb begin
      clr_row_in    = clr_row_ff;
      iss_in        = iss_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mlast_in      = mlast_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      ok_in         = ok_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_issue      = 1'b0;
      mem_raddr     = iss_ff[ROW_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = rd_row_ff;
      mem_wdata     = val_ff ? (mem_rdata | row_mask) : (mem_rdata & ~row_mask);

      // Drop the result word once it is taken.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         pfba_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_row_ff;
            mem_wdata  = '0;
            clr_row_in = clr_row_ff + ROW_W'(1);
         end
         pfba_pkg::ST_IDLE: begin
            if (req_acc) begin
               count_in = req_count;
               addr_in  = '0;
               if (req_tuser == pfba_pkg::FUNC_FREE) begin
                  ok_in    = 1'b1;
                  val_in   = 1'b1;
                  lo_in    = free_lo;
                  hi_in    = free_hi;
                  mlast_in = ROW_W'((free_hi - FRAME_W'(1)) >> pfba_pkg::POS_W);
                  iss_in   = RCNT_W'(free_lo >> pfba_pkg::POS_W);
               end else begin
                  ok_in  = 1'b0;
                  val_in = 1'b0;
                  iss_in = '0;
               end
            end
         end
         pfba_pkg::ST_SCAN: begin
            // Hold further reads once a run is found; the mark pass restarts them.
            rd_issue = (iss_ff < RCNT_W'(DEPTH)) && !scan_hit;
            if (rd_issue) begin
               iss_in = iss_ff + RCNT_W'(1);
            end
            if (scan_hit) begin
               lo_in    = hit_lo;
               hi_in    = scan_end;
               mlast_in = ROW_W'((scan_end - FRAME_W'(1)) >> pfba_pkg::POS_W);
               iss_in   = RCNT_W'(hit_lo >> pfba_pkg::POS_W);
               ok_in    = 1'b1;
               addr_in  = pfba_pkg::ADDR_W'({hit_lo, pfba_pkg::FRAME_SHIFT'(0)});
            end
         end
         pfba_pkg::ST_MARK: begin
            // Read row r+1 while writing back row r.
            rd_issue = (iss_ff <= RCNT_W'(mlast_ff));
            if (rd_issue) begin
               iss_in = iss_ff + RCNT_W'(1);
            end
            mem_we = rd_vld_ff;
         end
         pfba_pkg::ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = pfba_pkg::RSP_DATA_W'({ok_ff, addr_ff});
            end
         end
         default: begin
         end
      endcase

      rd_vld_in = rd_issue;
      rd_row_in = mem_raddr;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfba_pkg::ST_CLEAR;
         clr_row_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_row_ff    <= clr_row_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      rd_row_ff    <= rd_row_in;
      count_ff     <= count_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mlast_ff     <= mlast_in;
      val_ff       <= val_in;
      addr_ff      <= addr_in;
      ok_ff        <= ok_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- assertions
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_IDLE || state_ff == pfba_pkg::ST_SCAN) |-> !mem_we)
      else $error("map written outside the clear and mark passes");

   a_no_same_row: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_issue) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same row in one cycle");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_MARK && mem_we) |-> (rd_row_ff <= mlast_ff))
      else $error("row update past the last row of the range");

   a_alloc_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_MARK && !val_ff) |->
      (SUM_W'(hi_ff) - SUM_W'(lo_ff) == SUM_W'(count_ff)))
      else $error("allocated run length differs from the request");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfba_pkg::ST_RESP && (!rsp_tvalid_ff || rsp_tready)) |=> rsp_tvalid_ff)
      else $error("finished item left no result word");

endmodule

### rtl/pfba_bitmap_ram.sv
// Frame map storage: one write port, one read port with registered data.
module pfba_bitmap_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [pfba_pkg::SCAN_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [pfba_pkg::SCAN_BITS-1:0] rd_data
);

   logic [pfba_pkg::SCAN_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/pfba_run_scan.sv
// First-fit run finder: walks one map row per word and carries the run count.
module pfba_run_scan #(
   parameter int ROW_W   = 9,
   parameter int FRAME_W = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pfba_pkg::scan_ctl_type         ctl,
   input  logic [ROW_W-1:0]               row,
   input  logic [pfba_pkg::SCAN_BITS-1:0] data,
   input  logic [pfba_pkg::COUNT_W-1:0]   count,
   output logic                           hit,
   output logic [FRAME_W-1:0]             hit_end
);

   logic [pfba_pkg::COUNT_W-1:0] run_ff, run_in, run_v;
   logic                         found;
   logic [pfba_pkg::POS_W-1:0]   pos;

   // Count free frames bit by bit; stop at the first place the run is long enough.
   always_comb begin
      run_v = run_ff;
      found = 1'b0;
      pos   = '0;
      for (int j = 0; j < pfba_pkg::SCAN_BITS; j++) begin
         if (!found) begin
            if (data[j]) begin
               run_v = run_v + pfba_pkg::COUNT_W'(1);
            end else begin
               run_v = '0;
            end
            if (run_v == count) begin
               found = 1'b1;
               pos   = pfba_pkg::POS_W'(j);
            end
         end
      end
   end

   assign hit     = ctl.vld && found;
   assign hit_end = FRAME_W'({row, pos}) + FRAME_W'(1);

   always_comb begin
      if (ctl.clr) begin
         run_in = '0;
      end else if (ctl.vld) begin
         run_in = run_v;
      end else begin
         run_in = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule
